// ===== rtl/qbvg_pkg.sv =====
// ----------------------------------------------------------------------------
// qbvg_pkg
// Shared types and constants of the quad batch vertex generator.
// ----------------------------------------------------------------------------
package qbvg_pkg;

   localparam int MAX_QUADS_DEF = 1024;
   localparam int TEX_SLOTS_DEF = 16;

   localparam int REQ_DATA_W = 400;
   localparam int RSP_DATA_W = 248;

   // action codes
   localparam logic [1:0] ACT_BEGIN = 2'd0;
   localparam logic [1:0] ACT_DRAW  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_VERTEX = 2'd0;
   localparam logic [1:0] KIND_FLUSH  = 2'd1;
   localparam logic [1:0] KIND_BIND   = 2'd2;

   // sine polynomial constants
   localparam logic [14:0] TRIG_C1 = 15'd1160;
   localparam logic [14:0] TRIG_C2 = 15'd10512;
   localparam logic [14:0] TRIG_C3 = 15'd25736;

   typedef struct packed {
      logic       load_in;
      logic       trig_en;
      logic [1:0] trig_step;
      logic       prod_en;
      logic       start_batch;
      logic       emit_flush;
      logic       emit_bind;
      logic       emit_vert;
      logic [1:0] corner;
      logic       last;
      logic       slot_zero;
      logic       slot_hit;
      logic       add_idx;
   } qbvg_cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       idx_full;
      logic       idx_nz;
      logic       id_nz;
      logic       hit;
      logic       slots_full;
      logic       out_free;
   } qbvg_sts_type;

endpackage

// ===== rtl/qbvg_ctrl.sv =====
// ----------------------------------------------------------------------------
// qbvg_ctrl
// Sequencer: walks a draw item through decode, sine, products, batch checks,
// texture slot lookup and four corner results; begin and end stop at decode.
// ----------------------------------------------------------------------------
module qbvg_ctrl
   import qbvg_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  qbvg_sts_type sts,
   output qbvg_cmd_type cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DECODE = 3'd1;
   localparam logic [2:0] ST_TRIG   = 3'd2;
   localparam logic [2:0] ST_PROD   = 3'd3;
   localparam logic [2:0] ST_FULL   = 3'd4;
   localparam logic [2:0] ST_SLOT   = 3'd5;
   localparam logic [2:0] ST_VERT   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] cnt_ff, cnt_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_in = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.action)
               ACT_BEGIN: begin
                  cmd.start_batch = 1'b1;
                  state_in        = ST_IDLE;
               end
               ACT_END: begin
                  if (!sts.idx_nz) begin
                     state_in = ST_IDLE;
                  end else if (sts.out_free) begin
                     cmd.emit_flush = 1'b1;
                     cmd.last       = 1'b1;
                     state_in       = ST_IDLE;
                  end
               end
               ACT_DRAW: begin
                  cnt_in   = 2'd0;
                  state_in = ST_TRIG;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_TRIG: begin
            cmd.trig_en   = 1'b1;
            cmd.trig_step = cnt_ff;
            cnt_in        = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            cmd.prod_en = 1'b1;
            state_in    = ST_FULL;
         end
         ST_FULL: begin
            if (!sts.idx_full) begin
               state_in = ST_SLOT;
            end else if (!sts.idx_nz) begin
               cmd.start_batch = 1'b1;
               state_in        = ST_SLOT;
            end else if (sts.out_free) begin
               cmd.emit_flush  = 1'b1;
               cmd.start_batch = 1'b1;
               state_in        = ST_SLOT;
            end
         end
         ST_SLOT: begin
            cnt_in = 2'd0;
            if (!sts.id_nz) begin
               cmd.slot_zero = 1'b1;
               state_in      = ST_VERT;
            end else if (sts.hit) begin
               cmd.slot_hit = 1'b1;
               state_in     = ST_VERT;
            end else if (sts.slots_full) begin
               // slots exhausted: flush, restart, then bind on the next pass
               if (!sts.idx_nz) begin
                  cmd.start_batch = 1'b1;
               end else if (sts.out_free) begin
                  cmd.emit_flush  = 1'b1;
                  cmd.start_batch = 1'b1;
               end
            end else if (sts.out_free) begin
               cmd.emit_bind = 1'b1;
               state_in      = ST_VERT;
            end
         end
         ST_VERT: begin
            if (sts.out_free) begin
               cmd.emit_vert = 1'b1;
               cmd.corner    = cnt_ff;
               cnt_in        = cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  cmd.last    = 1'b1;
                  cmd.add_idx = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== rtl/qbvg_dp.sv =====
// ----------------------------------------------------------------------------
// qbvg_dp
// Datapath: item registers, sine/cosine lanes, corner products, batch state,
// texture slot table and the result register.
// ----------------------------------------------------------------------------
module qbvg_dp
   import qbvg_pkg::*;
#(
   parameter int MAX_QUADS = MAX_QUADS_DEF,
   parameter int TEX_SLOTS = TEX_SLOTS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  qbvg_cmd_type          cmd,
   output qbvg_sts_type          sts,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int IDX_W  = $clog2(6 * MAX_QUADS + 1);
   localparam int USED_W = $clog2(TEX_SLOTS + 1);
   localparam int SLOT_W = $clog2(TEX_SLOTS);

   // item registers
   logic [1:0]         action_ff;
   logic [31:0]        px_ff, py_ff, pz_ff;
   logic [15:0]        angle_ff;
   logic signed [31:0] sx_ff, sy_ff;
   logic [31:0]        colour_ff, id_ff, tiling_ff;
   logic [63:0]        cu_ff, cv_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         action_ff <= req_tuser;
         px_ff     <= req_tdata[31:0];
         py_ff     <= req_tdata[63:32];
         pz_ff     <= req_tdata[95:64];
         angle_ff  <= req_tdata[111:96];
         sx_ff     <= req_tdata[143:112];
         sy_ff     <= req_tdata[175:144];
         colour_ff <= req_tdata[207:176];
         id_ff     <= req_tdata[239:208];
         tiling_ff <= req_tdata[271:240];
         cu_ff     <= req_tdata[335:272];
         cv_ff     <= req_tdata[399:336];
      end
   end

   // sine lane 0, cosine lane 1; one multiply per lane per step
   logic [15:0]        lane_ang [2];
   logic [14:0]        lane_x   [2];
   logic [14:0]        mul_a    [2];
   logic [14:0]        mul_b    [2];
   logic [29:0]        mul_p    [2];
   logic [14:0]        x2_ff    [2];
   logic [14:0]        t_ff     [2];
   logic signed [17:0] trig_ff  [2];

   always_comb begin
      lane_ang[0] = angle_ff;
      lane_ang[1] = angle_ff + 16'd16384;
      for (int l = 0; l < 2; l++) begin
         lane_x[l] = lane_ang[l][14] ? (15'd16384 - {1'b0, lane_ang[l][13:0]})
                                     : {1'b0, lane_ang[l][13:0]};
         unique case (cmd.trig_step)
            2'd0: begin mul_a[l] = lane_x[l]; mul_b[l] = lane_x[l]; end
            2'd1: begin mul_a[l] = TRIG_C1;   mul_b[l] = x2_ff[l];  end
            2'd2: begin mul_a[l] = x2_ff[l];  mul_b[l] = t_ff[l];   end
            default: begin mul_a[l] = lane_x[l]; mul_b[l] = t_ff[l]; end
         endcase
         mul_p[l] = 30'(mul_a[l]) * 30'(mul_b[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trig_en) begin
         for (int l = 0; l < 2; l++) begin
            unique case (cmd.trig_step)
               2'd0: x2_ff[l] <= mul_p[l][28:14];
               2'd1: t_ff[l]  <= TRIG_C2 - mul_p[l][28:14];
               2'd2: t_ff[l]  <= TRIG_C3 - mul_p[l][28:14];
               default: begin
                  trig_ff[l] <= lane_ang[l][15]
                     ? -$signed({1'b0, mul_p[l][29:14], 1'b0})
                     :  $signed({1'b0, mul_p[l][29:14], 1'b0});
               end
            endcase
         end
      end
   end

   // corner products
   logic signed [49:0] pcx_ff, pss_ff, psx_ff, pcy_ff;

   always_ff @(posedge clock) begin
      if (cmd.prod_en) begin
         pcx_ff <= trig_ff[1] * sx_ff;
         pss_ff <= trig_ff[0] * sy_ff;
         psx_ff <= trig_ff[0] * sx_ff;
         pcy_ff <= trig_ff[1] * sy_ff;
      end
   end

   logic               ex, ey;
   logic signed [50:0] cx_e, ss_e, sx_e, cy_e, ax, ay, rx, ry;
   logic [31:0]        vx, vy;
   logic [15:0]        vu, vv;

   always_comb begin
      ex   = (cmd.corner == 2'd1) || (cmd.corner == 2'd2);
      ey   = cmd.corner[1];
      cx_e = {pcx_ff[49], pcx_ff};
      ss_e = {pss_ff[49], pss_ff};
      sx_e = {psx_ff[49], psx_ff};
      cy_e = {pcy_ff[49], pcy_ff};
      ax   = (ex ? cx_e : -cx_e) - (ey ? ss_e : -ss_e);
      ay   = (ex ? sx_e : -sx_e) + (ey ? cy_e : -cy_e);
      rx   = (ax + 51'sd32768) >>> 16;
      ry   = (ay + 51'sd32768) >>> 16;
      vx   = px_ff + rx[31:0];
      vy   = py_ff + ry[31:0];
      vu   = (id_ff != '0) ? cu_ff[16*cmd.corner +: 16] : 16'd0;
      vv   = (id_ff != '0) ? cv_ff[16*cmd.corner +: 16] : 16'd0;
   end

   // batch state
   logic [IDX_W-1:0]  idx_ff;
   logic [USED_W-1:0] used_ff;
   logic [SLOT_W-1:0] cur_slot_ff;
   logic [31:0]       slot_ids [TEX_SLOTS];
   logic              hit;
   logic [SLOT_W-1:0] hit_slot;

   always_comb begin
      hit      = 1'b0;
      hit_slot = '0;
      for (int i = 1; i < TEX_SLOTS; i++) begin
         if (!hit && (USED_W'(i) < used_ff) && (slot_ids[i] == id_ff)) begin
            hit      = 1'b1;
            hit_slot = SLOT_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         used_ff <= USED_W'(1);
      end else begin
         if (cmd.start_batch) begin
            idx_ff <= '0;
         end else if (cmd.add_idx) begin
            idx_ff <= idx_ff + IDX_W'(6);
         end
         if (cmd.start_batch) begin
            used_ff <= USED_W'(1);
         end else if (cmd.emit_bind) begin
            used_ff <= used_ff + USED_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_bind) begin
         slot_ids[used_ff[SLOT_W-1:0]] <= id_ff;
         cur_slot_ff                   <= used_ff[SLOT_W-1:0];
      end else if (cmd.slot_hit) begin
         cur_slot_ff <= hit_slot;
      end else if (cmd.slot_zero) begin
         cur_slot_ff <= '0;
      end
   end

   // result register
   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;
   logic [1:0]            kind_ff;
   logic                  last_ff;
   logic                  emit;

   assign emit = cmd.emit_flush || cmd.emit_bind || cmd.emit_vert;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (emit) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         last_ff <= cmd.last;
         priority if (cmd.emit_flush) begin
            kind_ff <= KIND_FLUSH;
            data_ff <= {7'd0, 13'(idx_ff), 228'd0};
         end else if (cmd.emit_bind) begin
            kind_ff <= KIND_BIND;
            data_ff <= {20'd0, id_ff, 32'd0, 4'(used_ff[SLOT_W-1:0]), 160'd0};
         end else begin
            kind_ff <= KIND_VERTEX;
            data_ff <= {7'd0, 13'd0, 32'd0, tiling_ff, 4'(cur_slot_ff), vv, vu,
                        colour_ff, pz_ff, vy, vx};
         end
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

   assign sts.action     = action_ff;
   assign sts.idx_full   = (idx_ff >= IDX_W'(6 * MAX_QUADS));
   assign sts.idx_nz     = (idx_ff != '0);
   assign sts.id_nz      = (id_ff != '0);
   assign sts.hit        = hit;
   assign sts.slots_full = (used_ff >= USED_W'(TEX_SLOTS));
   assign sts.out_free   = !valid_ff || rsp_tready;

endmodule

// ===== rtl/quad_batch_vertex_generator_unit.sv =====
// ----------------------------------------------------------------------------
// quad_batch_vertex_generator_unit
// Sprite quad batcher: turns draw items into four transformed vertices and
// emits texture bind and batch flush results as batches fill and on end scene.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser  | tlast
//  req_    | in  | pos_x..corner_v, 400 bits              | action | -
//  rsp_    | out | vert_x..flush_indices, 241 of 248 bits | kind   | last
//
//  Sequence: a draw goes from accept through decode, four sine polynomial
//  steps on two multiply lanes, the product step, batch check, slot check
//  and four vertex results; a full-batch flush and a bind ride in the batch
//  and slot check states, and running out of slots adds a flush and a
//  repeat of the slot check. Begin and end scene go idle after decode.
//  One item is in work at a time; req_tready is high only while idle.
//  Reset: synchronous, clears sequencer and batch index, slot count back to 1.
//  Stalls: a low rsp_tready freezes the sequencer at its next result.
// ----------------------------------------------------------------------------
module quad_batch_vertex_generator_unit
   import qbvg_pkg::*;
#(
   parameter int MAX_QUADS = MAX_QUADS_DEF,
   parameter int TEX_SLOTS = TEX_SLOTS_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pos_x, pos_y, pos_z, angle, size_x, size_y, colour, texture_id, tiling,
   // corner_u, corner_v
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // action
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // vert_x, vert_y, vert_z, vert_colour, vert_u, vert_v, slot, vert_tiling,
   // bound_id, flush_indices, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   qbvg_cmd_type cmd;
   qbvg_sts_type sts;

   // sequencer
   qbvg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // arithmetic, batch state and result register
   qbvg_dp #(
      .MAX_QUADS (MAX_QUADS),
      .TEX_SLOTS (TEX_SLOTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== rtl/qbvg_checker.sv =====
// ----------------------------------------------------------------------------
// qbvg_checker
// Port-level checks of the quad batch vertex generator.
// ----------------------------------------------------------------------------
module qbvg_checker
   import qbvg_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // one item at a time: no accept right after an accept
   a_req_single: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while busy");

   a_kind_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == KIND_VERTEX || rsp_tuser == KIND_FLUSH ||
                      rsp_tuser == KIND_BIND))
      else $error("bad result kind");

   // a flush carries only its index count, and it is never empty
   a_flush_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_FLUSH |->
         rsp_tdata[227:0] == '0 && rsp_tdata[240:228] != '0)
      else $error("malformed flush");

   // a bind is never the final result of an item
   a_bind_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_BIND |-> !rsp_tlast)
      else $error("bind marked last");

endmodule

bind quad_batch_vertex_generator_unit qbvg_checker u_qbvg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
